FILE: rtl/dspd_pkg.sv
// ----------------------------------------------------------------------------
// dspd_pkg
// Phase codes, register indexes and reset values of the dual PI drive unit.
// ----------------------------------------------------------------------------
package dspd_pkg;

	localparam int unsigned CfgIndexW = 3;
	localparam int unsigned CfgDataW  = 31;

	localparam logic [1:0] PH_FWD   = 2'd0;
	localparam logic [1:0] PH_PAUSE = 2'd1;
	localparam logic [1:0] PH_BACK  = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	localparam logic [CfgIndexW-1:0] REG_KP_GAIN       = 3'd0;
	localparam logic [CfgIndexW-1:0] REG_KI_GAIN       = 3'd1;
	localparam logic [CfgIndexW-1:0] REG_FWD_TARGET    = 3'd2;
	localparam logic [CfgIndexW-1:0] REG_BWD_TARGET    = 3'd3;
	localparam logic [CfgIndexW-1:0] REG_DISTANCE_GOAL = 3'd4;
	localparam logic [CfgIndexW-1:0] REG_DRIVE_LIMIT   = 3'd5;
	localparam logic [CfgIndexW-1:0] REG_PAUSE_PERIODS = 3'd6;

	localparam logic [17:0]        RST_KP_GAIN       = 18'd28672;
	localparam logic [17:0]        RST_KI_GAIN       = 18'd41;
	localparam logic signed [15:0] RST_FWD_TARGET    = 16'sd420;
	localparam logic signed [15:0] RST_BWD_TARGET    = -16'sd476;
	localparam logic [30:0]        RST_DISTANCE_GOAL = 31'd20200;
	localparam logic [12:0]        RST_DRIVE_LIMIT   = 13'd7199;
	localparam logic [7:0]         RST_PAUSE_PERIODS = 8'd5;

endpackage

FILE: rtl/distance_sequenced_dual_pi_drive_unit.sv
// ----------------------------------------------------------------------------
// distance_sequenced_dual_pi_drive_unit
// Forward, pause, backward, done sequencer driving two incremental PI loops.
// ----------------------------------------------------------------------------
// Each request on the input stream is one control period with the left and
// right encoder counts. The unit takes one request per clock cycle when the
// output is not stalled and returns one result per request, held in the input
// register and then the result register. The rate is set by the combinational
// update of the sequencer and PI accumulators, from the input register to the
// result register through the gain multipliers. Configuration must be written
// while no request is in flight.
module distance_sequenced_dual_pi_drive_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [15:0] left_count, [31:16] right_count
	input  logic [31:0]                    s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [13:0] left_drive, [27:14] right_drive, [29:28] phase,
	// [61:30] distance_travelled, [63:62] zero
	output logic [63:0]                    m_axis_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dspd_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [dspd_pkg::CfgDataW-1:0]  cfg_data
);
	import dspd_pkg::*;

	typedef struct packed {
		logic signed [13:0] acc;
		logic signed [17:0] prev;
	} pi_res_t;

	logic [17:0]        kp_q;
	logic [17:0]        ki_q;
	logic signed [15:0] fwd_target_q;
	logic signed [15:0] bwd_target_q;
	logic [30:0]        goal_q;
	logic [12:0]        limit_q;
	logic [7:0]         pause_periods_q;

	logic [1:0]         phase_q;
	logic signed [31:0] dist_q;
	logic [7:0]         pause_q;
	logic signed [13:0] left_acc_q;
	logic signed [13:0] right_acc_q;
	logic signed [17:0] left_prev_q;
	logic signed [17:0] right_prev_q;

	logic               in_valid_s1;
	logic [31:0]        in_data_s1;
	logic               m_valid_q;
	logic [63:0]        m_data_q;

	logic               advance;
	logic               step;
	logic signed [15:0] left_count;
	logic signed [15:0] right_count;
	logic signed [16:0] delta;
	logic signed [32:0] dist_sum;
	logic signed [31:0] dist_sat;
	logic               goal_hit;
	logic [7:0]         pause_inc;
	logic [1:0]         phase_n;
	logic signed [31:0] dist_n;
	logic [7:0]         pause_n;
	logic               clr;
	logic signed [15:0] target;
	pi_res_t            left_res;
	pi_res_t            right_res;
	logic signed [13:0] left_drive;
	logic signed [13:0] right_drive;

	function automatic pi_res_t pi_step(
		input logic signed [15:0] tgt,
		input logic signed [15:0] cnt,
		input logic signed [13:0] acc,
		input logic signed [17:0] prev,
		input logic [17:0]        kp,
		input logic [17:0]        ki,
		input logic [12:0]        lim
	);
		logic signed [16:0] e;
		logic signed [17:0] de;
		logic signed [36:0] p_term;
		logic signed [35:0] i_term;
		logic signed [37:0] sum;
		logic signed [37:0] sum_adj;
		logic signed [25:0] inc;
		logic signed [26:0] acc_sum;
		logic signed [26:0] lim_pos;
		pi_res_t            res;
		e       = 17'({tgt[15], tgt}) - 17'({cnt[15], cnt});
		de      = 18'({e[16], e}) - prev;
		p_term  = $signed({1'b0, kp}) * de;
		i_term  = $signed({1'b0, ki}) * e;
		sum     = 38'(p_term) + 38'(i_term);
		sum_adj = sum + $signed({26'd0, {12{sum[37]}}});
		inc     = sum_adj[37:12];
		acc_sum = 27'(acc) + 27'(inc);
		lim_pos = $signed({14'd0, lim});
		if (acc_sum > lim_pos) begin
			acc_sum = lim_pos;
		end else if (acc_sum < -lim_pos) begin
			acc_sum = -lim_pos;
		end
		res.acc  = acc_sum[13:0];
		res.prev = 18'(e);
		return res;
	endfunction

	assign cfg_ready     = 1'b1;
	assign advance       = !m_valid_q || m_axis_tready;
	assign step          = in_valid_s1 && advance;
	assign s_axis_tready = !in_valid_s1 || advance;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	assign left_count  = in_data_s1[15:0];
	assign right_count = in_data_s1[31:16];

	always_comb begin
		delta     = (phase_q == PH_BACK) ? -17'(left_count) : 17'(left_count);
		dist_sum  = 33'(dist_q) + 33'(delta);
		if (dist_sum[32] != dist_sum[31]) begin
			dist_sat = dist_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			dist_sat = dist_sum[31:0];
		end
		goal_hit  = dist_sat >= $signed({1'b0, goal_q});
		pause_inc = (pause_q == 8'hFF) ? pause_q : pause_q + 8'd1;

		phase_n = phase_q;
		dist_n  = dist_q;
		pause_n = pause_q;
		clr     = 1'b0;
		unique case (phase_q)
			PH_FWD: begin
				dist_n = dist_sat;
				if (goal_hit) begin
					phase_n = PH_PAUSE;
					pause_n = '0;
				end
			end
			PH_PAUSE: begin
				pause_n = pause_inc;
				if (pause_inc >= pause_periods_q) begin
					phase_n = PH_BACK;
					dist_n  = '0;
					clr     = 1'b1;
				end
			end
			PH_BACK: begin
				dist_n = dist_sat;
				if (goal_hit) begin
					phase_n = PH_DONE;
				end
			end
			PH_DONE: begin
			end
		endcase

		priority if (phase_n == PH_FWD) begin
			target = fwd_target_q;
		end else if (phase_n == PH_BACK) begin
			target = bwd_target_q;
		end else begin
			target = '0;
		end

		left_res  = pi_step(target, left_count, clr ? 14'sd0 : left_acc_q,
			clr ? 18'sd0 : left_prev_q, kp_q, ki_q, limit_q);
		right_res = pi_step(target, right_count, clr ? 14'sd0 : right_acc_q,
			clr ? 18'sd0 : right_prev_q, kp_q, ki_q, limit_q);

		if (phase_n == PH_FWD || phase_n == PH_BACK) begin
			left_drive  = left_res.acc;
			right_drive = right_res.acc;
		end else begin
			left_drive  = '0;
			right_drive = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q            <= RST_KP_GAIN;
			ki_q            <= RST_KI_GAIN;
			fwd_target_q    <= RST_FWD_TARGET;
			bwd_target_q    <= RST_BWD_TARGET;
			goal_q          <= RST_DISTANCE_GOAL;
			limit_q         <= RST_DRIVE_LIMIT;
			pause_periods_q <= RST_PAUSE_PERIODS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KP_GAIN:       kp_q            <= cfg_data[17:0];
				REG_KI_GAIN:       ki_q            <= cfg_data[17:0];
				REG_FWD_TARGET:    fwd_target_q    <= cfg_data[15:0];
				REG_BWD_TARGET:    bwd_target_q    <= cfg_data[15:0];
				REG_DISTANCE_GOAL: goal_q          <= cfg_data[30:0];
				REG_DRIVE_LIMIT:   limit_q         <= cfg_data[12:0];
				REG_PAUSE_PERIODS: pause_periods_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_data_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FWD;
			dist_q       <= '0;
			pause_q      <= '0;
			left_acc_q   <= '0;
			right_acc_q  <= '0;
			left_prev_q  <= '0;
			right_prev_q <= '0;
		end else if (step) begin
			phase_q      <= phase_n;
			dist_q       <= dist_n;
			pause_q      <= pause_n;
			left_acc_q   <= left_res.acc;
			right_acc_q  <= right_res.acc;
			left_prev_q  <= left_res.prev;
			right_prev_q <= right_res.prev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			m_data_q <= {2'b00, dist_n, phase_n, right_drive, left_drive};
		end
	end

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("sequencer left the done phase");

	a_idle_drives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && (m_data_q[29:28] == PH_PAUSE || m_data_q[29:28] == PH_DONE)
		|-> m_data_q[27:0] == 28'd0)
		else $error("drive sent out while stopped");

	a_state_only_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q) && $stable(dist_q) && $stable(left_acc_q))
		else $error("control state changed without a request");

	a_output_follows_step: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> m_valid_q && m_data_q[29:28] == phase_q)
		else $error("result does not match the updated phase");

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the distance sequenced dual PI drive unit.
// ----------------------------------------------------------------------------
// Control periods are queued by the stimulus process and streamed in by a
// clocked driver. A clocked monitor compares every result with a prediction
// made when the request was accepted. The run starts under reset settings.
// It then sweeps gains, targets and limits while moving forward. Next it
// drives full-scale left counts until the forward run ends at the goal.
// It holds and releases the pause, sweeps the backward run, and runs on in
// done. Both stream sides idle in random bursts, except in quiet stretches.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dspd_pkg::*;

	typedef struct {
		logic signed [15:0] lc;
		logic signed [15:0] rc;
	} period_t;

	typedef struct {
		logic signed [13:0] ldrv;
		logic signed [13:0] rdrv;
		logic [1:0]         ph;
		logic signed [31:0] travelled;
	} drive_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [31:0]          s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [63:0]          m_axis_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0]  cfg_data = '0;

	period_t       period_q[$];
	drive_result_t predicted_q[$];
	period_t       bus_item;
	drive_result_t want_r;
	int            send_gap = 0;
	int            recv_stall = 0;
	bit            idle_on = 1'b1;
	int            fails = 0;
	int            periods_done = 0;
	int            reg_writes = 0;

	longint kp_m, ki_m, fwd_m, bwd_m, goal_m, lim_m, pp_m;
	logic [1:0] ph_m;
	longint dist_m, pcount_m, lacc_m, racc_m, lprev_m, rprev_m;

	distance_sequenced_dual_pi_drive_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint drive_step(input longint acc, input longint e, input longint prev);
		longint s;
		longint a;
		s = kp_m * (e - prev) + ki_m * e;
		a = acc + s / 4096;
		if (a > lim_m) a = lim_m;
		if (a < -lim_m) a = -lim_m;
		return a;
	endfunction

	function automatic drive_result_t predict_period(input period_t p);
		longint target;
		longint el;
		longint er;
		drive_result_t r;
		case (ph_m)
			PH_FWD: begin
				dist_m = clamp32(dist_m + longint'(p.lc));
				if (dist_m >= goal_m) begin
					ph_m = PH_PAUSE;
					pcount_m = 0;
				end
			end
			PH_PAUSE: begin
				if (pcount_m < 255) pcount_m++;
				if (pcount_m >= pp_m) begin
					ph_m = PH_BACK;
					dist_m = 0;
					lacc_m = 0;
					racc_m = 0;
					lprev_m = 0;
					rprev_m = 0;
				end
			end
			PH_BACK: begin
				dist_m = clamp32(dist_m - longint'(p.lc));
				if (dist_m >= goal_m) ph_m = PH_DONE;
			end
			default: ;
		endcase
		target = (ph_m == PH_FWD) ? fwd_m : (ph_m == PH_BACK) ? bwd_m : 0;
		el = target - longint'(p.lc);
		er = target - longint'(p.rc);
		lacc_m = drive_step(lacc_m, el, lprev_m);
		racc_m = drive_step(racc_m, er, rprev_m);
		lprev_m = el;
		rprev_m = er;
		r.ldrv = (ph_m == PH_PAUSE || ph_m == PH_DONE) ? 14'sd0 : lacc_m[13:0];
		r.rdrv = (ph_m == PH_PAUSE || ph_m == PH_DONE) ? 14'sd0 : racc_m[13:0];
		r.ph = ph_m;
		r.travelled = dist_m[31:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			send_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predicted_q.push_back(predict_period(bus_item));
				periods_done++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (period_q.size() > 0) begin
					bus_item = period_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {bus_item.rc, bus_item.lc};
					if (idle_on && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 8);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			fails++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (predicted_q.size() == 0) begin
					fails++;
					$error("result: expected none pending, got %h", m_axis_tdata);
				end else begin
					want_r = predicted_q.pop_front();
					check_field("left_drive", want_r.ldrv, $signed(m_axis_tdata[13:0]));
					check_field("right_drive", want_r.rdrv, $signed(m_axis_tdata[27:14]));
					check_field("phase", want_r.ph, m_axis_tdata[29:28]);
					check_field("distance_travelled", want_r.travelled,
						$signed(m_axis_tdata[61:30]));
					check_field("pad", 0, m_axis_tdata[63:62]);
				end
			end
			if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (idle_on && $urandom_range(0, 7) == 0) recv_stall <= $urandom_range(1, 8);
			end
		end
	end

	task automatic set_reg(input logic [CfgIndexW-1:0] idx, input longint val);
		logic [CfgDataW-1:0] d;
		d = val[CfgDataW-1:0];
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
			REG_KP_GAIN:       kp_m = longint'(d[17:0]);
			REG_KI_GAIN:       ki_m = longint'(d[17:0]);
			REG_FWD_TARGET:    fwd_m = longint'($signed(d[15:0]));
			REG_BWD_TARGET:    bwd_m = longint'($signed(d[15:0]));
			REG_DISTANCE_GOAL: goal_m = longint'(d[30:0]);
			REG_DRIVE_LIMIT:   lim_m = longint'(d[12:0]);
			REG_PAUSE_PERIODS: pp_m = longint'(d[7:0]);
			default: ;
		endcase
	endtask

	task automatic gain_set(input longint kp, input longint ki, input longint ft,
			input longint bt, input longint lim);
		set_reg(REG_KP_GAIN, kp);
		set_reg(REG_KI_GAIN, ki);
		set_reg(REG_FWD_TARGET, ft);
		set_reg(REG_BWD_TARGET, bt);
		set_reg(REG_DRIVE_LIMIT, lim);
	endtask

	function automatic logic signed [15:0] rnd16();
		logic [31:0] r;
		r = $urandom();
		return r[15:0];
	endfunction

	function automatic logic signed [15:0] near(input longint center, input int spread);
		longint v;
		v = center + longint'($urandom_range(0, 2 * spread)) - spread;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	task automatic push(input longint lc, input longint rc);
		period_t p;
		p.lc = lc[15:0];
		p.rc = rc[15:0];
		period_q.push_back(p);
	endtask

	// Most periods follow the target closely; the rest are arbitrary counts.
	task automatic push_random(input int n, input longint center);
		repeat (n) begin
			if ($urandom_range(0, 9) < 7) push(near(center, 600), near(center, 600));
			else push(rnd16(), rnd16());
		end
	endtask

	task automatic drain();
		while (period_q.size() != 0 || s_axis_tvalid || predicted_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		kp_m = RST_KP_GAIN;
		ki_m = RST_KI_GAIN;
		fwd_m = RST_FWD_TARGET;
		bwd_m = RST_BWD_TARGET;
		goal_m = RST_DISTANCE_GOAL;
		lim_m = RST_DRIVE_LIMIT;
		pp_m = RST_PAUSE_PERIODS;
		ph_m = PH_FWD;
		dist_m = 0;
		pcount_m = 0;
		lacc_m = 0;
		racc_m = 0;
		lprev_m = 0;
		rprev_m = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push(0, 0);
		push(1, -1);
		push(-1, 1);
		push(420, 420);
		push(-32768, 32767);
		push(0, -32768);
		push(32767, 32767);
		push(-476, -476);
		drain();

		set_reg(REG_DISTANCE_GOAL, 64'h7FFF_FFFF);
		set_reg(REG_PAUSE_PERIODS, 255);
		gain_set(262143, 262143, 32767, -32768, 8191);
		push(32767, -32768);
		push(-32768, 32767);
		push(32767, 32767);
		push(-32768, -32768);
		push_random(80, fwd_m);
		drain();
		gain_set(0, 0, 0, 0, 0);
		push_random(60, fwd_m);
		drain();
		for (int i = 0; i < 3; i++) begin
			idle_on = (i != 1);
			if (i == 0)
				gain_set($urandom_range(0, 262143), $urandom_range(0, 262143), rnd16(), rnd16(),
					$urandom_range(0, 8191));
			else
				gain_set($urandom_range(0, 32767), $urandom_range(0, 4095), rnd16(), rnd16(),
					$urandom_range(0, 8191));
			push_random(100, fwd_m);
			drain();
		end
		idle_on = 1'b1;
		gain_set(RST_KP_GAIN, RST_KI_GAIN, RST_FWD_TARGET, RST_BWD_TARGET, RST_DRIVE_LIMIT);
		push_random(60, fwd_m);
		drain();

		// Climb with full-scale left counts until the forward run reaches its goal.
		idle_on = 1'b0;
		set_reg(REG_DISTANCE_GOAL, (dist_m < 0 ? 0 : dist_m) + $urandom_range(0, 100000));
		while (ph_m == PH_FWD) begin
			repeat (8) push(32767, rnd16());
			drain();
		end
		set_reg(REG_DISTANCE_GOAL, 64'h7FFF_FFFF);

		idle_on = 1'b1;
		push_random(30, 0);
		drain();
		gain_set($urandom_range(0, 32767), $urandom_range(0, 4095), rnd16(), -476, 7199);
		set_reg(REG_PAUSE_PERIODS, 0);
		push(rnd16(), rnd16());
		drain();

		for (int i = 0; i < 3; i++) begin
			idle_on = (i != 2);
			if (i == 1)
				gain_set($urandom_range(0, 262143), $urandom_range(0, 262143), rnd16(), rnd16(),
					$urandom_range(0, 8191));
			else if (i == 2)
				gain_set($urandom_range(0, 32767), $urandom_range(0, 4095), rnd16(), rnd16(),
					$urandom_range(0, 8191));
			push_random(80, bwd_m);
			drain();
		end

		idle_on = 1'b1;
		set_reg(REG_DISTANCE_GOAL, (dist_m < 0 ? 0 : dist_m) + $urandom_range(0, 100000));
		while (ph_m != PH_DONE) begin
			repeat (8) push(-longint'($urandom_range(8192, 32768)), rnd16());
			drain();
		end

		gain_set($urandom_range(0, 262143), $urandom_range(0, 262143), rnd16(), rnd16(),
			$urandom_range(0, 8191));
		set_reg(REG_DISTANCE_GOAL, 0);
		set_reg(REG_PAUSE_PERIODS, $urandom_range(0, 255));
		push_random(60, 0);
		drain();
		idle_on = 1'b0;
		push_random(40, bwd_m);
		drain();
		repeat (8) @(posedge clk);

		$display("Streamed %0d control periods with %0d register writes through forward,",
			periods_done, reg_writes);
		$display("pause, backward and done, with gains, targets and limits swept on the way.");
		if (fails == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
